/* hw/rtl/rhsc_pkg.sv */
// Package for the beacon-homing steering controller.
// Holds the shared constants, mode codes, register indexes and the controller/datapath structs.
// No dependencies.
package rhsc_pkg;

  localparam int DEFAULT_ANGLE_FRAC_BITS = 8;

  localparam int unsigned RATE_DIV    = 131000;
  localparam int unsigned RATE_HALF   = 65500;
  localparam int unsigned SEEK_MAX_MS = 9000;
  localparam int unsigned TURN_MAX_MS = 2500;
  localparam logic signed [15:0] RSSI_FLOOR = -16'sd32512;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_BIAS    = 3'd0,
    REG_RSSI_ALPHA   = 3'd1,
    REG_LOST_MS      = 3'd2,
    REG_TREND_THRESH = 3'd3,
    REG_TREND_LIMIT  = 3'd4,
    REG_FORWARD_PWM  = 3'd5,
    REG_TURN_PWM     = 3'd6,
    REG_YAW_DEADBAND = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_SEEK = 2'd1;
  localparam logic [1:0] MODE_TURN = 2'd2;

  typedef struct packed {
    logic cap;
    logic mul;
    logic prep;
    logic div_step;
    logic upd;
    logic dec;
  } dp_cmd_t;

  typedef struct packed {
    logic first_tick;
    logic div_last;
  } dp_status_t;

endpackage

/* hw/rtl/rhsc_ifs.sv */
// Channel interfaces for the steering controller: tick input, result output, configuration.
// No dependencies; the register index width is written out as three bits.
interface rhsc_tick_if;
  logic               valid;
  logic               ready;
  logic [31:0]        now_ms;
  logic signed [15:0] gyro_raw;
  logic signed [7:0]  rssi_sample;
  logic               beacon_seen;
  logic [31:0]        last_seen_ms;
  modport source (output valid, now_ms, gyro_raw, rssi_sample, beacon_seen, last_seen_ms,
                  input ready);
  modport sink (input valid, now_ms, gyro_raw, rssi_sample, beacon_seen, last_seen_ms,
                output ready);
endinterface

interface rhsc_result_if #(parameter int ANGLE_W = 17);
  logic               valid;
  logic               ready;
  logic [7:0]         left_pwm;
  logic [7:0]         right_pwm;
  logic [1:0]         drive_mode;
  logic [ANGLE_W-1:0] heading;
  logic signed [15:0] rssi_smoothed;
  modport source (output valid, left_pwm, right_pwm, drive_mode, heading, rssi_smoothed,
                  input ready);
  modport sink (input valid, left_pwm, right_pwm, drive_mode, heading, rssi_smoothed,
                output ready);
endinterface

interface rhsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rhsc_ctrl.sv */
// Sequencing state machine of the steering controller.
// Depends on rhsc_pkg for the command and status structs.
module rhsc_ctrl
  import rhsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_UPD  = 6'b010000,
    S_DEC  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.first_tick ? S_UPD : S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        // The result register must be free before the decision overwrites it.
        if (!out_valid || out_ready) begin
          cmd.dec        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/rhsc_datapath.sv */
// Datapath of the steering controller: registers, yaw integrator, reciprocal divider, filter,
// modes. Depends on rhsc_pkg for constants, mode codes and the command and status structs.
module rhsc_datapath
  import rhsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEFAULT_ANGLE_FRAC_BITS,
  parameter int AW = 9 + ANGLE_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [31:0]        now_ms,
  input  logic signed [15:0] gyro_raw,
  input  logic signed [7:0]  rssi_sample,
  input  logic               beacon_seen,
  input  logic [31:0]        last_seen_ms,
  output logic [7:0]         left_pwm,
  output logic [7:0]         right_pwm,
  output logic [1:0]         drive_mode,
  output logic [AW-1:0]      heading,
  output logic signed [15:0] rssi_smoothed
);

  localparam int PROD_W = 49;
  // A full turn is 45 << SH in the angle format.
  localparam int SH     = ANGLE_FRAC_BITS + 3;
  localparam int CNT_W  = 4;
  localparam logic [CNT_W-1:0] DIV_STEPS = 4'd12;
  localparam int CW     = (AW > 16) ? AW + 1 : 17;
  localparam logic [AW-1:0] FULL  = AW'(360 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] HALF  = AW'(180 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] STEP  = AW'(10 << ANGLE_FRAC_BITS);
  localparam logic [AW-1:0] SWEEP = AW'(220 << ANGLE_FRAC_BITS);
  // The rate divisor and rounding offset are divided by eight, as is the scaled product.
  localparam int unsigned QDIV  = RATE_DIV / 8;
  localparam int unsigned ZBIAS = RATE_HALF / 8;
  // ceil(2^44 / 16375), exact for 30-bit partial dividends.
  localparam logic [30:0] QRECIP = 31'd1074331973;
  // ceil(2^28 / 45), exact for 22-bit values.
  localparam logic [22:0] MRECIP = 23'd5965233;

  typedef enum logic [2:0] {
    PH_QUOT = 3'b001,
    PH_REM  = 3'b010,
    PH_FOLD = 3'b100
  } div_phase_t;

  // Configuration registers.
  logic signed [15:0] gyro_bias;
  logic [8:0]         rssi_alpha_q8;
  logic [15:0]        lost_ms;
  logic [11:0]        trend_thresh_q8;
  logic [7:0]         trend_limit, forward_pwm, turn_pwm;
  logic [15:0]        yaw_deadband;

  // Captured tick.
  logic [31:0]        now_r, last_seen_r;
  logic signed [15:0] gyro_r;
  logic signed [7:0]  sample_r;
  logic               seen_r;

  // Controller state.
  logic [AW-1:0]      yaw_angle, turn_target, seek_start_heading, seek_next_heading;
  logic [AW-1:0]      seek_best_heading;
  logic [31:0]        last_tick_ms, turn_start_ms, seek_start_ms;
  logic signed [15:0] rssi_filtered, seek_best_rssi;
  logic [7:0]         bad_trend_count;
  logic [1:0]         mode_reg;

  // Arithmetic work registers.
  logic [PROD_W-1:0]  prod;
  logic               rate_neg;
  logic signed [17:0] fprod_new;
  logic signed [25:0] fprod_old;
  logic [63:0]        zreg;
  logic [13:0]        rem;
  logic [15:0]        qd;
  logic [AW+15:0]     vreg;
  logic [15:0]        qx;
  logic [AW-1:0]      qmod;
  logic [CNT_W-1:0]   div_cnt;
  div_phase_t         div_phase;
  logic signed [16:0] trend;

  assign status.first_tick = (last_tick_ms == 32'd0);
  assign status.div_last   = (div_cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias       <= 16'sd0;
      rssi_alpha_q8   <= 9'd31;
      lost_ms         <= 16'd1200;
      trend_thresh_q8 <= 12'd154;
      trend_limit     <= 8'd18;
      forward_pwm     <= 8'd160;
      turn_pwm        <= 8'd140;
      yaw_deadband    <= 16'd1536;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GYRO_BIAS:    gyro_bias       <= $signed(cfg_data);
        REG_RSSI_ALPHA:   rssi_alpha_q8   <= cfg_data[8:0];
        REG_LOST_MS:      lost_ms         <= cfg_data;
        REG_TREND_THRESH: trend_thresh_q8 <= cfg_data[11:0];
        REG_TREND_LIMIT:  trend_limit     <= cfg_data[7:0];
        REG_FORWARD_PWM:  forward_pwm     <= cfg_data[7:0];
        REG_TURN_PWM:     turn_pwm        <= cfg_data[7:0];
        REG_YAW_DEADBAND: yaw_deadband    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiply stage operands.
  logic signed [16:0] rate;
  logic [16:0]        rate_mag;
  logic [31:0]        dt;
  logic [8:0]         alpha;
  assign rate     = 17'(gyro_r) - 17'(gyro_bias);
  assign rate_mag = rate[16] ? 17'(-rate) : rate;
  assign dt       = now_r - last_tick_ms;
  assign alpha    = (rssi_alpha_q8 > 9'd256) ? 9'd256 : rssi_alpha_q8;

  // Long division by 16375 in 16-bit digits. Each digit takes three steps: a reciprocal
  // multiply for the quotient digit, the remainder update, and a fold of the digit into
  // the quotient modulo a full turn (a reciprocal multiply by 1/45 above the low SH bits).
  logic [29:0]    tnum;
  logic [60:0]    qd_prod;
  logic [29:0]    rem_full;
  logic [AW+15:0] vnow;
  logic [21:0]    xnow;
  logic [44:0]    qx_prod;
  logic [21:0]    xv;
  logic [21:0]    rfold;
  assign tnum     = {rem, zreg[63:48]};
  assign qd_prod  = 61'(tnum) * 61'(QRECIP);
  assign rem_full = tnum - 30'(qd) * 30'(QDIV);
  assign vnow     = {qmod, qd};
  assign xnow     = vnow[AW+15:SH];
  assign qx_prod  = 45'(xnow) * 45'(MRECIP);
  assign xv       = vreg[AW+15:SH];
  assign rfold    = xv - 22'(qx) * 22'd45;

  // Filter sum and yaw update.
  logic signed [27:0] fsum;
  logic signed [15:0] filt_new;
  logic [AW:0]        yaw_sum;
  logic [AW-1:0]      yaw_new;
  assign fsum     = (28'(fprod_new) <<< 8) + 28'(fprod_old) + 28'sd128;
  assign filt_new = fsum[23:8];
  assign yaw_sum  = rate_neg ? ({1'b0, yaw_angle} - {1'b0, qmod})
                             : ({1'b0, yaw_angle} + {1'b0, qmod});
  always_comb begin
    if (rate_neg) yaw_new = yaw_sum[AW] ? AW'(yaw_sum + {1'b0, FULL}) : yaw_sum[AW-1:0];
    else yaw_new = (yaw_sum >= {1'b0, FULL}) ? AW'(yaw_sum - {1'b0, FULL})
                                              : yaw_sum[AW-1:0];
  end

  // Mode decision.
  logic          lost;
  logic [7:0]    turn_third;
  logic [16:0]   third_prod;
  logic [AW:0]   prog_raw, next_raw;
  logic [AW-1:0] prog, next_rel, next_adv;
  logic [AW:0]   next_sum;
  logic signed [AW+1:0] diff0, diff;
  logic [AW:0]   adiff;
  logic signed [17:0] trend_cmp;
  logic [7:0]    cnt1;

  assign lost       = !seen_r || ((now_r - last_seen_r) > {16'd0, lost_ms});
  assign third_prod = 17'(turn_pwm) * 17'd171;
  assign turn_third = third_prod[16:9];
  assign prog_raw   = {1'b0, yaw_angle} - {1'b0, seek_start_heading};
  assign prog       = prog_raw[AW] ? AW'(prog_raw + {1'b0, FULL}) : prog_raw[AW-1:0];
  assign next_raw   = {1'b0, seek_next_heading} - {1'b0, seek_start_heading};
  assign next_rel   = next_raw[AW] ? AW'(next_raw + {1'b0, FULL}) : next_raw[AW-1:0];
  assign next_sum   = {1'b0, seek_next_heading} + {1'b0, STEP};
  assign next_adv   = (next_sum >= {1'b0, FULL}) ? AW'(next_sum - {1'b0, FULL})
                                                  : next_sum[AW-1:0];
  assign diff0      = $signed({2'b00, turn_target}) - $signed({2'b00, yaw_angle});
  always_comb begin
    diff = diff0;
    if (diff0 > $signed({2'b00, HALF})) diff = diff0 - $signed({2'b00, FULL});
    else if (diff0 < -$signed({2'b00, HALF})) diff = diff0 + $signed({2'b00, FULL});
  end
  assign adiff     = diff[AW+1] ? (AW+1)'(-diff) : diff[AW:0];
  assign trend_cmp = 18'(trend) + $signed({6'd0, trend_thresh_q8});
  always_comb begin
    cnt1 = bad_trend_count;
    if (trend_cmp < 0) begin
      if (bad_trend_count != 8'd255) cnt1 = bad_trend_count + 8'd1;
    end else if (bad_trend_count != 8'd0) begin
      cnt1 = bad_trend_count - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle          <= '0;
      last_tick_ms       <= '0;
      rssi_filtered      <= RSSI_FLOOR;
      bad_trend_count    <= '0;
      mode_reg           <= MODE_SEEK;
      turn_target        <= '0;
      turn_start_ms      <= '0;
      seek_start_heading <= '0;
      seek_next_heading  <= '0;
      seek_start_ms      <= '0;
      seek_best_heading  <= '0;
      seek_best_rssi     <= RSSI_FLOOR;
      div_cnt            <= '0;
      div_phase          <= PH_QUOT;
    end else begin
      if (cmd.cap) begin
        now_r       <= now_ms;
        gyro_r      <= gyro_raw;
        sample_r    <= rssi_sample;
        seen_r      <= beacon_seen;
        last_seen_r <= last_seen_ms;
      end
      if (cmd.mul) begin
        prod      <= PROD_W'(rate_mag) * PROD_W'(dt);
        rate_neg  <= rate[16];
        fprod_new <= $signed({1'b0, alpha}) * sample_r;
        fprod_old <= $signed({1'b0, 9'd256 - alpha}) * rssi_filtered;
      end
      if (cmd.prep) begin
        zreg      <= (64'(prod) << (ANGLE_FRAC_BITS - 3)) + 64'(ZBIAS);
        rem       <= '0;
        qmod      <= '0;
        div_cnt   <= DIV_STEPS;
        div_phase <= PH_QUOT;
      end
      if (cmd.div_step) begin
        unique case (div_phase)
          PH_QUOT: begin
            qd        <= qd_prod[59:44];
            div_phase <= PH_REM;
          end
          PH_REM: begin
            rem       <= rem_full[13:0];
            zreg      <= zreg << 16;
            vreg      <= vnow;
            qx        <= qx_prod[43:28];
            div_phase <= PH_FOLD;
          end
          PH_FOLD: begin
            qmod      <= {rfold[5:0], vreg[SH-1:0]};
            div_phase <= PH_QUOT;
          end
          default: div_phase <= PH_QUOT;
        endcase
        div_cnt <= div_cnt - CNT_W'(1);
      end
      if (cmd.upd) begin
        if (!status.first_tick) yaw_angle <= yaw_new;
        last_tick_ms  <= now_r;
        rssi_filtered <= filt_new;
        trend         <= 17'(filt_new) - 17'(rssi_filtered);
      end
      if (cmd.dec) begin
        left_pwm  <= 8'd0;
        right_pwm <= 8'd0;
        drive_mode <= mode_reg;
        case (mode_reg)
          MODE_FWD: begin
            if (lost) begin
              seek_start_ms <= now_r;  seek_start_heading <= yaw_angle;
              seek_next_heading <= yaw_angle;  seek_best_heading <= yaw_angle;
              seek_best_rssi <= RSSI_FLOOR;  mode_reg <= MODE_SEEK;
              drive_mode <= MODE_SEEK;
            end else if (cnt1 >= trend_limit) begin
              bad_trend_count <= 8'd0;
              seek_start_ms <= now_r;  seek_start_heading <= yaw_angle;
              seek_next_heading <= yaw_angle;  seek_best_heading <= yaw_angle;
              seek_best_rssi <= RSSI_FLOOR;  mode_reg <= MODE_SEEK;
              drive_mode <= MODE_SEEK;
            end else begin
              bad_trend_count <= cnt1;
              left_pwm  <= forward_pwm;
              right_pwm <= forward_pwm;
            end
          end
          MODE_SEEK: begin
            if ((now_r - seek_start_ms) > SEEK_MAX_MS) begin
              turn_target <= seek_best_heading;  turn_start_ms <= now_r;
              mode_reg <= MODE_TURN;  drive_mode <= MODE_TURN;
            end else if (lost) begin
              left_pwm  <= turn_third;
              right_pwm <= turn_pwm;
            end else begin : seek_sample
              logic [AW-1:0] best_h;
              logic take;
              take   = (prog >= next_rel) && (rssi_filtered > seek_best_rssi);
              best_h = take ? yaw_angle : seek_best_heading;
              if (prog >= next_rel) seek_next_heading <= next_adv;
              if (take) begin
                seek_best_rssi    <= rssi_filtered;
                seek_best_heading <= yaw_angle;
              end
              if (prog >= SWEEP) begin
                turn_target <= best_h;  turn_start_ms <= now_r;
                mode_reg <= MODE_TURN;  drive_mode <= MODE_TURN;
              end else begin
                left_pwm  <= turn_third;
                right_pwm <= turn_pwm;
              end
            end
          end
          default: begin
            if (((now_r - turn_start_ms) > TURN_MAX_MS) ||
                (CW'(adiff) <= CW'(yaw_deadband))) begin
              mode_reg <= MODE_FWD;  drive_mode <= MODE_FWD;
            end else if (diff > 0) begin
              left_pwm  <= turn_third;
              right_pwm <= turn_pwm;
            end else begin
              left_pwm  <= turn_pwm;
              right_pwm <= turn_third;
            end
          end
        endcase
        heading       <= yaw_angle;
        rssi_smoothed <= rssi_filtered;
      end
    end
  end

endmodule

/* hw/rtl/rssi_homing_steer_controller_unit.sv */
// Top level of the beacon-homing steering controller.
// Depends on rhsc_pkg, the channel interfaces, rhsc_ctrl and rhsc_datapath.
//
// One transaction on the tick channel carries one control tick: the time, the gyro z
// sample, the latest beacon strength and the sighting status. For every tick the block
// returns exactly one transaction on the result channel with both motor duties, the mode
// after the tick, the wrapped heading and the filtered strength.
// An accepted tick passes the multiply, divider set-up, divider, update and decision
// steps; the very first tick after reset, which only records time, skips the divider.
// The divider scales the yaw step by 1/131000: four 16-bit quotient digits of three
// steps each, using reciprocal multiplies. One tick is worked on at a time; the next
// tick is accepted once the previous result is in the output register.
// If the receiver stalls, the finished result is held, and a later tick runs up to its
// decision step and waits there until the held result is taken.
// The configuration channel is always ready and writes one register per transaction; it
// should be used only while no tick is in flight.
// Reset (synchronous, active high) restores all register defaults, clears the yaw and
// timers, sets the filter to -127 dBm and starts in seek mode with no result pending.
module rssi_homing_steer_controller_unit
  import rhsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = DEFAULT_ANGLE_FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  rhsc_tick_if.sink   tick,
  rhsc_result_if.source result,
  rhsc_cfg_if.sink    cfg
);

  localparam int AW = 9 + ANGLE_FRAC_BITS;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Register writes complete in the same cycle they are offered.
  assign cfg.ready = 1'b1;

  rhsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  rhsc_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .AW              (AW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .now_ms        (tick.now_ms),
    .gyro_raw      (tick.gyro_raw),
    .rssi_sample   (tick.rssi_sample),
    .beacon_seen   (tick.beacon_seen),
    .last_seen_ms  (tick.last_seen_ms),
    .left_pwm      (result.left_pwm),
    .right_pwm     (result.right_pwm),
    .drive_mode    (result.drive_mode),
    .heading       (result.heading),
    .rssi_smoothed (result.rssi_smoothed)
  );

endmodule

/* bench/rssi_homing_steer_controller_unit_tb.sv */
// Self-checking testbench for the beacon-homing steering controller top level.
// It depends on rhsc_pkg, the channel interfaces and rssi_homing_steer_controller_unit.
`timescale 1ns / 1ps

module rssi_homing_steer_controller_unit_tb;
  import rhsc_pkg::*;

  // These angle constants assume the default Q.8 angle format.
  localparam longint FULL_TURN  = 360 * 256;
  localparam longint HALF_TURN  = 180 * 256;
  localparam longint SEEK_STEP  = 10 * 256;
  localparam longint SEEK_SWEEP = 220 * 256;
  localparam int     TICK_LATENCY = 80;

  typedef struct {
    logic [31:0]        now_ms;
    logic signed [15:0] gyro_raw;
    logic signed [7:0]  rssi_sample;
    logic               beacon_seen;
    logic [31:0]        last_seen_ms;
  } tick_t;

  typedef struct {
    logic [7:0]         left_pwm;
    logic [7:0]         right_pwm;
    logic [1:0]         drive_mode;
    logic [16:0]        heading;
    logic signed [15:0] rssi_smoothed;
  } steer_t;

  // The steering tracker mirrors the controller state. Every accepted tick advances it
  // and queues the steering result that the block has to return for that tick.
  class steer_tracker;
    int          bias;
    int unsigned alpha, lost_ms, trend_thresh, trend_limit, fwd_pwm, turn_pwm, deadband;
    longint      yaw;
    logic [31:0] last_tick;
    int          filt, prev_filt;
    int unsigned bad_count;
    logic [1:0]  mode;
    longint      turn_target;
    logic [31:0] turn_start;
    longint      seek_start_hdg, seek_next_hdg, seek_best_hdg;
    logic [31:0] seek_start;
    int          seek_best_rssi;
    steer_t      pending[$];
    int          mismatches;
    int          checked;

    function new();
      bias = 0; alpha = 31; lost_ms = 1200; trend_thresh = 154; trend_limit = 18;
      fwd_pwm = 160; turn_pwm = 140; deadband = 1536;
      yaw = 0; last_tick = 0; filt = -127 * 256; prev_filt = -127 * 256;
      bad_count = 0; mode = MODE_SEEK; turn_target = 0; turn_start = 0;
      seek_start_hdg = 0; seek_next_hdg = 0; seek_best_hdg = 0; seek_start = 0;
      seek_best_rssi = -127 * 256; mismatches = 0; checked = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] data);
      case (idx)
        REG_GYRO_BIAS:    bias = $signed(data);
        REG_RSSI_ALPHA:   alpha = data[8:0];
        REG_LOST_MS:      lost_ms = data;
        REG_TREND_THRESH: trend_thresh = data[11:0];
        REG_TREND_LIMIT:  trend_limit = data[7:0];
        REG_FORWARD_PWM:  fwd_pwm = data[7:0];
        REG_TURN_PWM:     turn_pwm = data[7:0];
        REG_YAW_DEADBAND: deadband = data;
        default: ;
      endcase
    endfunction

    function longint wrap(longint a);
      longint r;
      r = a % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return r;
    endfunction

    function void start_seek(logic [31:0] now);
      seek_start = now;
      seek_start_hdg = yaw;
      seek_next_hdg = yaw;
      seek_best_hdg = yaw;
      seek_best_rssi = -127 * 256;
      mode = MODE_SEEK;
    endfunction

    function void start_turn(longint target, logic [31:0] now);
      turn_target = wrap(target);
      turn_start = now;
      mode = MODE_TURN;
    endfunction

    function void note_tick(tick_t t);
      logic [31:0]     dt, since_seen;
      int              rate, trend;
      longint unsigned mag, q;
      longint          step, a, acc, prog, next_prog, diff, adiff;
      int unsigned     lpwm, rpwm;
      bit              lost;
      steer_t          r;
      lpwm = 0;
      rpwm = 0;
      // Yaw integration; a zero last tick time means no time base has been recorded yet.
      if (last_tick == 0) begin
        last_tick = t.now_ms;
      end else begin
        dt = t.now_ms - last_tick;
        last_tick = t.now_ms;
        rate = int'(t.gyro_raw) - bias;
        mag = longint'(rate < 0 ? -rate : rate) * longint'(dt);
        mag = mag << 8;
        q = (mag + 65500) / 131000;
        step = longint'(q % FULL_TURN);
        if (rate < 0) step = -step;
        yaw = wrap(yaw + step);
      end
      // Exponential filter rounded to nearest; alpha saturates at one.
      a = (alpha > 256) ? 256 : alpha;
      acc = a * longint'(t.rssi_sample) * 256 + (256 - a) * longint'(filt) + 128;
      filt = int'(acc >>> 8);
      trend = filt - prev_filt;
      prev_filt = filt;
      since_seen = t.now_ms - t.last_seen_ms;
      lost = !t.beacon_seen || (since_seen > lost_ms);

      if (mode == MODE_FWD) begin
        if (lost) begin
          start_seek(t.now_ms);
        end else begin
          lpwm = fwd_pwm;
          rpwm = fwd_pwm;
          if (trend < -int'(trend_thresh)) begin
            if (bad_count < 255) bad_count++;
          end else if (bad_count > 0) begin
            bad_count--;
          end
          if (bad_count >= trend_limit) begin
            bad_count = 0;
            lpwm = 0;
            rpwm = 0;
            start_seek(t.now_ms);
          end
        end
      end else if (mode == MODE_SEEK) begin
        dt = t.now_ms - seek_start;
        if (dt > SEEK_MAX_MS) begin
          start_turn(seek_best_hdg, t.now_ms);
        end else begin
          lpwm = turn_pwm / 3;
          rpwm = turn_pwm;
          // The sweep only samples while the beacon is heard.
          if (!lost) begin
            prog = wrap(yaw - seek_start_hdg);
            next_prog = wrap(seek_next_hdg - seek_start_hdg);
            if (prog >= next_prog) begin
              if (filt > seek_best_rssi) begin
                seek_best_rssi = filt;
                seek_best_hdg = yaw;
              end
              seek_next_hdg = wrap(seek_next_hdg + SEEK_STEP);
            end
            if (prog >= SEEK_SWEEP) begin
              lpwm = 0;
              rpwm = 0;
              start_turn(seek_best_hdg, t.now_ms);
            end
          end
        end
      end else begin
        diff = turn_target - yaw;
        if (diff > HALF_TURN) diff -= FULL_TURN;
        if (diff < -HALF_TURN) diff += FULL_TURN;
        adiff = diff < 0 ? -diff : diff;
        dt = t.now_ms - turn_start;
        if (dt > TURN_MAX_MS || adiff <= longint'(deadband)) begin
          mode = MODE_FWD;
        end else if (diff > 0) begin
          lpwm = turn_pwm / 3;
          rpwm = turn_pwm;
        end else begin
          lpwm = turn_pwm;
          rpwm = turn_pwm / 3;
        end
      end

      r.left_pwm = lpwm[7:0];
      r.right_pwm = rpwm[7:0];
      r.drive_mode = mode;
      r.heading = yaw[16:0];
      r.rssi_smoothed = filt[15:0];
      pending.push_back(r);
    endfunction

    function void check_result(steer_t got);
      steer_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected steering result, nothing pending (left %0d right %0d)",
                 $time, got.left_pwm, got.right_pwm);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.left_pwm !== exp_r.left_pwm) begin
        $display("%0t: left_pwm expected %0d actual %0d", $time, exp_r.left_pwm, got.left_pwm);
        mismatches++;
      end
      if (got.right_pwm !== exp_r.right_pwm) begin
        $display("%0t: right_pwm expected %0d actual %0d", $time, exp_r.right_pwm,
                 got.right_pwm);
        mismatches++;
      end
      if (got.drive_mode !== exp_r.drive_mode) begin
        $display("%0t: drive_mode expected %0d actual %0d", $time, exp_r.drive_mode,
                 got.drive_mode);
        mismatches++;
      end
      if (got.heading !== exp_r.heading) begin
        $display("%0t: heading expected %0d actual %0d", $time, exp_r.heading, got.heading);
        mismatches++;
      end
      if (got.rssi_smoothed !== exp_r.rssi_smoothed) begin
        $display("%0t: rssi_smoothed expected %0d actual %0d", $time, exp_r.rssi_smoothed,
                 got.rssi_smoothed);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhsc_tick_if               tick_ch();
  rhsc_result_if #(.ANGLE_W(17)) result_ch();
  rhsc_cfg_if                cfg_ch();

  rssi_homing_steer_controller_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #1 clk = ~clk;

  steer_tracker tracker = new();

  // Idle percentages for the tick sender and the result receiver; the stimulus process
  // changes them between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Simulated wall clock and beacon level used by the scenario generator.
  logic [31:0] sim_ms = 32'd100;
  int          beacon_level = -70;
  int          ticks_sent = 0;
  int          phases_run = 0;

  // The receiver throttles ready at random; the monitor checks every accepted result.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (result_ch.valid && result_ch.ready) begin
        steer_t got;
        got.left_pwm = result_ch.left_pwm;
        got.right_pwm = result_ch.right_pwm;
        got.drive_mode = result_ch.drive_mode;
        got.heading = result_ch.heading;
        got.rssi_smoothed = result_ch.rssi_smoothed;
        tracker.check_result(got);
      end
    end
  end

  // Sends one tick. The sender may idle first; valid stays high across back-to-back
  // transactions so it is never lowered and raised within one time step.
  task automatic send_tick(tick_t t);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.now_ms <= t.now_ms;
    tick_ch.gyro_raw <= t.gyro_raw;
    tick_ch.rssi_sample <= t.rssi_sample;
    tick_ch.beacon_seen <= t.beacon_seen;
    tick_ch.last_seen_ms <= t.last_seen_ms;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    tracker.note_tick(t);
    ticks_sent++;
  endtask

  task automatic send_fields(logic [31:0] now, int gyro, int rssi, bit seen,
                             logic [31:0] last_seen);
    tick_t t;
    t.now_ms = now;
    t.gyro_raw = gyro[15:0];
    t.rssi_sample = rssi[7:0];
    t.beacon_seen = seen;
    t.last_seen_ms = last_seen;
    send_tick(t);
  endtask

  // Configuration is only written once every pending result has come back and the
  // block has had time to drain.
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY) @(posedge clk);
  endtask

  task automatic write_all_regs(logic [15:0] vals[8]);
    cfg_reg_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      tracker.write_reg(idx, vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Register sets: power-on values, both extremes, and a random but sensible set.
  function automatic void pick_config(int kind, output logic [15:0] vals[8]);
    case (kind)
      0: vals = '{16'd0, 16'd31, 16'd1200, 16'd154, 16'd18, 16'd160, 16'd140, 16'd1536};
      1: vals = '{16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      2: vals = '{16'h7FFF, 16'd511, 16'hFFFF, 16'd4095, 16'd255, 16'd255, 16'd255,
                  16'hFFFF};
      default: begin
        vals[0] = 16'($urandom_range(0, 1000)) - 16'd500;
        vals[1] = ($urandom_range(0, 3) == 0) ? 16'd256 : 16'($urandom_range(0, 300));
        vals[2] = 16'($urandom_range(200, 3000));
        vals[3] = 16'($urandom_range(0, 600));
        vals[4] = 16'($urandom_range(1, 30));
        vals[5] = 16'($urandom_range(0, 255));
        vals[6] = 16'($urandom_range(0, 255));
        vals[7] = 16'($urandom_range(0, 5000));
      end
    endcase
  endfunction

  // Builds one tick that follows the controller's current mode: strong left spins while
  // seeking, either-way yaw while turning, a drifting beacon while driving forward.
  // A share of the ticks are pure noise across every field.
  task automatic make_tick(output tick_t t);
    int          gyro, rssi, span;
    logic [31:0] dt;
    if ($urandom_range(0, 99) < 12) begin
      t.now_ms = $urandom();
      t.gyro_raw = $urandom();
      t.rssi_sample = $urandom();
      t.beacon_seen = $urandom_range(0, 1);
      t.last_seen_ms = $urandom();
      sim_ms = t.now_ms;
      return;
    end
    dt = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 3000) : $urandom_range(5, 120);
    sim_ms += dt;
    case (tracker.mode)
      MODE_SEEK: gyro = ($urandom_range(0, 99) < 80) ? $urandom_range(3000, 32767)
                                                       : $urandom_range(0, 300);
      MODE_TURN: gyro = $urandom_range(0, 40000) - 20000;
      default:   gyro = $urandom_range(0, 400) - 200;
    endcase
    gyro = gyro + tracker.bias;
    if (gyro > 32767) gyro = 32767;
    if (gyro < -32768) gyro = -32768;
    if (tracker.mode == MODE_FWD) beacon_level += $urandom_range(0, 10) - 6;
    else beacon_level += $urandom_range(0, 10) - 5;
    if (beacon_level > 127) beacon_level = 127;
    if (beacon_level < -128) beacon_level = -128;
    rssi = beacon_level + $urandom_range(0, 6) - 3;
    if (rssi > 127) rssi = 127;
    if (rssi < -128) rssi = -128;
    span = tracker.lost_ms + tracker.lost_ms / 5 + 1;
    t.now_ms = sim_ms;
    t.gyro_raw = gyro[15:0];
    t.rssi_sample = rssi[7:0];
    t.beacon_seen = ($urandom_range(0, 99) < 95);
    t.last_seen_ms = sim_ms - $urandom_range(0, span);
  endtask

  initial begin : watchdog
    #5ms;
    $display("%0t: run timed out with %0d results pending", $time, tracker.pending.size());
    $display("rssi_homing_steer_controller_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] vals[8];
    tick_t       t;
    tick_ch.valid <= 1'b0;
    tick_ch.now_ms <= '0;
    tick_ch.gyro_raw <= '0;
    tick_ch.rssi_sample <= '0;
    tick_ch.beacon_seen <= 1'b0;
    tick_ch.last_seen_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_GYRO_BIAS;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks under the power-on register values. Zero time stamps keep the
    // controller in its first-tick state, then the field extremes, a lost beacon, a
    // millisecond counter wrap and a return to a zero time stamp.
    send_fields(32'd0, 32767, -128, 1'b0, 32'd0);
    send_fields(32'd0, -32768, 127, 1'b1, 32'd0);
    send_fields(32'd20, 100, -60, 1'b1, 32'd20);
    send_fields(32'd40, 32767, -50, 1'b1, 32'd40);
    send_fields(32'd60, -32768, 127, 1'b1, 32'd60);
    send_fields(32'd80, 0, -128, 1'b1, 32'd80);
    send_fields(32'd100, 32767, 127, 1'b0, 32'hFFFF_FFFF);
    send_fields(32'd5000, 32767, 0, 1'b1, 32'd1000);
    send_fields(32'hFFFF_FFF0, -1, -1, 1'b1, 32'hFFFF_FFF0);
    send_fields(32'h0000_0010, 32767, 10, 1'b1, 32'hFFFF_FFF8);
    send_fields(32'd0, 1, 20, 1'b1, 32'd0);
    send_fields(32'd30, 20000, 30, 1'b1, 32'd30);
    send_fields(32'hAAAA_5555, 16'h5555, 8'h55, 1'b1, 32'hAAAA_5555);
    send_fields(32'h5555_AAAA, -21846, -86, 1'b1, 32'h5555_AAAA);
    sim_ms = 32'h5555_AAAA;
    for (int i = 0; i < 10; i++) begin
      make_tick(t);
      send_tick(t);
    end
    phases_run++;

    // Random phases. Each writes a fresh register set and uses one idling pattern.
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      pick_config((p / 2 + p) % 4, vals);
      write_all_regs(vals);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int i = 0; i < 122; i++) begin
        make_tick(t);
        send_tick(t);
      end
      phases_run++;
    end

    tick_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY) @(posedge clk);

    $display("Sent %0d ticks over %0d phases; %0d results checked, %0d mismatches.",
             ticks_sent, phases_run, tracker.checked, tracker.mismatches);
    $display("Register sets covered power-on values, both extremes and random settings.");
    if (tracker.mismatches == 0) begin
      $display("rssi_homing_steer_controller_unit regression: pass");
    end else begin
      $display("rssi_homing_steer_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rhsc_pkg.sv
hw/rtl/rhsc_ifs.sv
hw/rtl/rhsc_ctrl.sv
hw/rtl/rhsc_datapath.sv
hw/rtl/rssi_homing_steer_controller_unit.sv
bench/rssi_homing_steer_controller_unit_tb.sv
